>>> design/lrs_pkg.sv
// shared types, codes and helpers for the linear regression sgd block
package lrs_pkg;

    localparam int DEFAULT_MAX_FEATURES = 16;
    localparam int WEIGHT_W  = 32;
    localparam int FEAT_W    = 16;
    localparam int ACC_W     = 48;
    localparam int DELTA_W   = 34;
    localparam int RATE_W    = 16;
    localparam int FCOUNT_W  = 5;
    localparam int LOAD_IDX_W = 5;

    localparam logic [LOAD_IDX_W-1:0] BIAS_SELECT = 5'd16;

    localparam logic [1:0] FUNC_PREDICT = 2'd0;
    localparam logic [1:0] FUNC_TRAIN   = 2'd1;
    localparam logic [1:0] FUNC_LOAD    = 2'd2;

    localparam logic REG_LEARNING_RATE = 1'b0;
    localparam logic REG_FEATURE_COUNT = 1'b1;

    localparam logic [RATE_W-1:0]   LEARNING_RATE_RESET = 16'd655;
    localparam logic [FCOUNT_W-1:0] FEATURE_COUNT_RESET = 5'd16;

    typedef struct packed {
        logic [1:0]                    func;
        logic signed [FEAT_W-1:0]      feature_value;
        logic signed [WEIGHT_W-1:0]    target;
        logic [LOAD_IDX_W-1:0]         weight_index;
        logic signed [WEIGHT_W-1:0]    weight_value;
    } item_t;

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] prediction;
        logic signed [WEIGHT_W-1:0] error;
        logic                       updated;
    } result_t;

    // update token walking down the cell row
    typedef struct packed {
        logic                      valid;
        logic signed [DELTA_W-1:0] delta;
    } cell_tok_t;

    function automatic logic signed [WEIGHT_W-1:0] sat32(input logic signed [63:0] x);
        logic signed [WEIGHT_W-1:0] r;
        if (x > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[WEIGHT_W-1:0];
        return r;
    endfunction

endpackage

>>> design/lrs_cell.sv
// one weight cell: holds a weight and its buffered feature, runs its own update step
module lrs_cell
    import lrs_pkg::*;
#(
    parameter int MAX_FEATURES = DEFAULT_MAX_FEATURES,
    parameter int CELL_INDEX   = 0
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  cell_tok_t                         tok_in,
    output cell_tok_t                         tok_out,
    input  logic [RATE_W-1:0]                 rate,
    input  logic [$clog2(MAX_FEATURES+1)-1:0] update_count,
    input  logic                              load_en,
    input  logic signed [WEIGHT_W-1:0]        load_value,
    input  logic                              feat_en,
    input  logic signed [FEAT_W-1:0]          feat_value,
    output logic signed [WEIGHT_W-1:0]        weight
);

    logic signed [WEIGHT_W-1:0] weight_reg, weight_next;
    logic signed [FEAT_W-1:0]   feat_reg;
    logic                       tok_valid_reg;
    logic signed [DELTA_W-1:0]  tok_delta_reg;
    logic                       stage_a_reg, stage_b_reg;
    logic signed [49:0]         grad_prod_reg, grad_prod_next;
    logic signed [59:0]         step_prod_reg, step_prod_next;
    logic                       cell_active;
    logic signed [50:0]         grad_round;
    logic signed [42:0]         grad;
    logic signed [60:0]         step_round;
    logic signed [44:0]         step;
    logic signed [45:0]         weight_diff;

    // only cells below the sample's feature count take part
    assign cell_active = tok_in.valid && (CELL_INDEX < int'(update_count));

    assign grad_prod_next = $signed(tok_in.delta) * feat_reg;

    // g = round(delta * feature / 2^8)
    assign grad_round     = {grad_prod_reg[49], grad_prod_reg} + 51'sd128;
    assign grad           = grad_round[50:8];
    assign step_prod_next = grad * $signed({1'b0, rate});

    // step = round(g * rate / 2^16)
    assign step_round  = {step_prod_reg[59], step_prod_reg} + 61'sd32768;
    assign step        = step_round[60:16];
    assign weight_diff = {{14{weight_reg[WEIGHT_W-1]}}, weight_reg} - {step[44], step};

    always_comb
    begin
        weight_next = weight_reg;
        if (load_en)
            weight_next = load_value;
        else if (stage_b_reg)
            weight_next = sat32(64'(weight_diff));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg    <= '0;
            tok_valid_reg <= 1'b0;
            stage_a_reg   <= 1'b0;
            stage_b_reg   <= 1'b0;
        end
        else
        begin
            weight_reg    <= weight_next;
            tok_valid_reg <= tok_in.valid;
            stage_a_reg   <= cell_active;
            stage_b_reg   <= stage_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (feat_en)
            feat_reg <= feat_value;
        tok_delta_reg <= tok_in.delta;
        grad_prod_reg <= grad_prod_next;
        step_prod_reg <= step_prod_next;
    end

    assign tok_out.valid = tok_valid_reg;
    assign tok_out.delta = tok_delta_reg;
    assign weight        = weight_reg;

endmodule

>>> design/linear_regression_sgd.sv
// top level: sample sequencer, accumulator, bias unit and the row of weight cells
//
// Linear regressor with per-sample gradient descent, signed fixed point.
// item channel (item_valid/item_ready, payload item): one feature per transfer
// under func predict or train, or a weight/bias load under func load.
// result channel (result_valid/result_ready, payload result): one result on the
// last feature of each sample with prediction, error and updated.
// cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): learning_rate and
// feature_count, always ready; the user must write them only while the block
// is idle, which the block itself does not enforce.
// A load or ignored code is taken in idle; a feature that does not end its
// sample is weight-multiplied, then accumulated; the last feature goes through
// multiply, accumulate, bias add with saturation and error to its result.
// In train mode the update token then walks the cell row, one cell per cycle with
// a 3-stage multiply pipeline in each, and no items are taken until it is done.
// The result sits in an output register; a stalled receiver holds the block
// only when the next result is ready to be written.
// Reset clears weights, bias, accumulator and sample position, and restores
// learning_rate 655 and feature_count 16.
module linear_regression_sgd
    import lrs_pkg::*;
#(
    parameter int MAX_FEATURES = DEFAULT_MAX_FEATURES
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_ready,
    input  item_t         item,
    output logic          result_valid,
    input  logic          result_ready,
    output result_t       result,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [15:0]   cfg_data
);

    localparam int CNT_W    = $clog2(MAX_FEATURES + 1);
    localparam int IDX_W    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int UPD_LAST = MAX_FEATURES + 1;
    localparam int UPD_W    = $clog2(MAX_FEATURES + 2);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ACC  = 5'b00010,
        S_PRED = 5'b00100,
        S_EMIT = 5'b01000,
        S_UPD  = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic [RATE_W-1:0]          rate_reg;
    logic [FCOUNT_W-1:0]        fcount_reg;
    logic [CNT_W-1:0]           pos_reg, pos_next;
    logic [CNT_W-1:0]           n_reg, n_next;
    logic [CNT_W-1:0]           count_eff;
    logic [CNT_W-1:0]           pos_inc;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [ACC_W-1:0]    acc_sum;
    logic signed [WEIGHT_W-1:0] bias_reg, bias_next;
    logic signed [ACC_W-1:0]    prod_reg;
    logic                       train_reg;
    logic signed [WEIGHT_W-1:0] target_reg;
    logic signed [WEIGHT_W-1:0] pred_reg;
    logic signed [48:0]         pred_sum;
    logic signed [32:0]         err;
    logic [UPD_W-1:0]           upd_cnt_reg, upd_cnt_next;
    logic                       out_valid_reg, out_valid_next;
    result_t                    out_reg;
    logic                       out_load;
    cell_tok_t                  tok_reg, tok_next;
    logic                       bias_v_reg;
    logic signed [50:0]         bias_prod_reg;
    logic signed [51:0]         bias_round;
    logic signed [35:0]         bias_step;
    logic signed [36:0]         bias_diff;
    logic                       item_fire, feat_fire, load_fire, load_bias;
    logic [IDX_W-1:0]           pos_idx;
    logic signed [WEIGHT_W-1:0] weight_sel;

    cell_tok_t                  tok_chain [MAX_FEATURES+1];
    logic signed [WEIGHT_W-1:0] cell_weight [MAX_FEATURES];

    assign item_ready = (state_reg == S_IDLE);
    assign item_fire  = item_valid && item_ready;
    assign feat_fire  = item_fire && (item.func inside {FUNC_PREDICT, FUNC_TRAIN});
    assign load_fire  = item_fire && (item.func == FUNC_LOAD);
    assign load_bias  = load_fire && (item.weight_index == BIAS_SELECT);
    assign cfg_ready  = 1'b1;

    assign pos_idx    = pos_reg[IDX_W-1:0];
    assign weight_sel = cell_weight[pos_idx];
    assign pos_inc    = pos_reg + 1'b1;

    // zero acts as one, anything above the cell count as the cell count
    always_comb
    begin
        if (fcount_reg == '0)
            count_eff = CNT_W'(1);
        else if (int'(fcount_reg) > MAX_FEATURES)
            count_eff = CNT_W'(MAX_FEATURES);
        else
            count_eff = CNT_W'(fcount_reg);
    end

    assign acc_sum  = acc_reg + (prod_reg >>> 8);
    assign pred_sum = {acc_reg[ACC_W-1], acc_reg}
                    + {{17{bias_reg[WEIGHT_W-1]}}, bias_reg};
    assign err      = {pred_reg[WEIGHT_W-1], pred_reg} - {target_reg[WEIGHT_W-1], target_reg};
    assign out_load = (state_reg == S_EMIT) && (!out_valid_reg || result_ready);

    // bias step = round(delta * rate / 2^16)
    assign bias_round = {bias_prod_reg[50], bias_prod_reg} + 52'sd32768;
    assign bias_step  = bias_round[51:16];
    assign bias_diff  = {{5{bias_reg[WEIGHT_W-1]}}, bias_reg} - {bias_step[35], bias_step};

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        n_next         = n_reg;
        acc_next       = acc_reg;
        upd_cnt_next   = upd_cnt_reg;
        tok_next.valid = 1'b0;
        tok_next.delta = {err, 1'b0};
        out_valid_next = out_valid_reg && !result_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (feat_fire)
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                acc_next = acc_sum;
                if (pos_inc >= count_eff)
                begin
                    n_next     = pos_inc;
                    pos_next   = '0;
                    state_next = S_PRED;
                end
                else
                begin
                    pos_next   = pos_inc;
                    state_next = S_IDLE;
                end
            end
            S_PRED:
            begin
                acc_next   = '0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    upd_cnt_next   = '0;
                    if (train_reg)
                    begin
                        tok_next.valid = 1'b1;
                        state_next     = S_UPD;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            S_UPD:
            begin
                upd_cnt_next = upd_cnt_reg + 1'b1;
                if (upd_cnt_reg == UPD_W'(UPD_LAST))
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        bias_next = bias_reg;
        if (load_bias)
            bias_next = item.weight_value;
        else if (bias_v_reg)
            bias_next = sat32(64'(bias_diff));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rate_reg      <= LEARNING_RATE_RESET;
            fcount_reg    <= FEATURE_COUNT_RESET;
            pos_reg       <= '0;
            n_reg         <= '0;
            acc_reg       <= '0;
            bias_reg      <= '0;
            upd_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            tok_reg       <= '0;
            bias_v_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            n_reg         <= n_next;
            acc_reg       <= acc_next;
            bias_reg      <= bias_next;
            upd_cnt_reg   <= upd_cnt_next;
            out_valid_reg <= out_valid_next;
            tok_reg       <= tok_next;
            bias_v_reg    <= tok_reg.valid;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LEARNING_RATE: rate_reg   <= cfg_data;
                    REG_FEATURE_COUNT: fcount_reg <= cfg_data[FCOUNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (feat_fire)
        begin
            prod_reg   <= weight_sel * item.feature_value;
            train_reg  <= (item.func == FUNC_TRAIN);
            target_reg <= item.target;
        end
        if (state_reg == S_PRED)
            pred_reg <= sat32(64'(pred_sum));
        if (out_load)
        begin
            out_reg.prediction <= pred_reg;
            out_reg.error      <= train_reg ? sat32(64'(err)) : '0;
            out_reg.updated    <= train_reg;
        end
        bias_prod_reg <= tok_reg.delta * $signed({1'b0, rate_reg});
    end

    assign tok_chain[0] = tok_reg;

    for (genvar i = 0; i < MAX_FEATURES; i++)
    begin : g_cell
        lrs_cell #(
            .MAX_FEATURES (MAX_FEATURES),
            .CELL_INDEX   (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .tok_in       (tok_chain[i]),
            .tok_out      (tok_chain[i+1]),
            .rate         (rate_reg),
            .update_count (n_reg),
            .load_en      (load_fire && !load_bias && (int'(item.weight_index) == i)),
            .load_value   (item.weight_value),
            .feat_en      (feat_fire && (pos_idx == IDX_W'(i))),
            .feat_value   (item.feature_value),
            .weight       (cell_weight[i])
        );
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // the update token is launched only by a train result
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_reg.valid |-> ($past(state_reg) == S_EMIT) && train_reg)
        else $error("update token without a train result");

    // a new result appears only out of the error step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> ($past(state_reg) == S_EMIT))
        else $error("result raised outside the error step");

    // sample position always addresses a real cell between samples
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (int'(pos_reg) < MAX_FEATURES))
        else $error("sample position past the last cell");

    // update pass ends after its fixed length
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) && (upd_cnt_reg == UPD_W'(UPD_LAST)) |=> (state_reg == S_IDLE))
        else $error("update pass did not end on time");

endmodule

>>> tb/sv/linear_regression_sgd_test.sv
// self-checking testbench for the linear regression sgd block
`timescale 1ns / 100ps

module linear_regression_sgd_test;
    import lrs_pkg::*;

    localparam int NFEAT = DEFAULT_MAX_FEATURES;
    localparam int GRAD_SCALE = 2;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS = 725;
    localparam int PRINT_CAP = 50;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam longint Q16_MAX = 64'sd2147483647;
    localparam longint Q16_MIN = -64'sd2147483648;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          item_valid = 1'b0;
    logic          item_ready;
    item_t         item_data = '0;
    logic          result_valid;
    logic          result_ready = 1'b0;
    result_t       result_data;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic          cfg_index = 1'b0;
    logic [15:0]   cfg_data = '0;

    // predictor state
    logic signed [31:0] coef_q[NFEAT];
    logic signed [31:0] bias_q;
    logic signed [15:0] feat_hist[NFEAT];
    longint             dot_sum;
    int unsigned        sample_pos;
    logic [15:0]        step_rate;
    logic [4:0]         sample_len;

    item_t   item_feed[$];
    result_t predicted_results[$];
    result_t next_want;
    int      mismatch_count = 0;
    int      item_gap = 0;
    int      item_calm = 0;
    int      ready_hold = 0;
    int      ready_calm = 0;

    linear_regression_sgd uut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item_data),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic signed [31:0] clamp_q16(input longint x);
        if (x > Q16_MAX)
            return Q16_MAX[31:0];
        if (x < Q16_MIN)
            return Q16_MIN[31:0];
        return x[31:0];
    endfunction

    // add half, then floor
    function automatic longint round_shift(input longint x, input int k);
        return (x + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    function automatic void clear_model();
        for (int i = 0; i < NFEAT; i++)
        begin
            coef_q[i] = '0;
            feat_hist[i] = '0;
        end
        bias_q = '0;
        dot_sum = 0;
        sample_pos = 0;
        step_rate = LEARNING_RATE_RESET;
        sample_len = FEATURE_COUNT_RESET;
    endfunction

    function automatic void regress_step(input item_t it);
        int unsigned span;
        int unsigned used;
        int i;
        longint err;
        longint delta;
        longint g;
        longint step;
        logic signed [31:0] pred32;
        result_t r;
        if (it.func == FUNC_LOAD)
        begin
            if (it.weight_index == BIAS_SELECT)
                bias_q = it.weight_value;
            else if (it.weight_index < NFEAT)
                coef_q[it.weight_index] = it.weight_value;
            return;
        end
        if (it.func == FUNC_UNUSED)
            return;
        span = (sample_len == 0) ? 1 : (sample_len > NFEAT) ? NFEAT : sample_len;
        if (sample_pos >= NFEAT)
            sample_pos = 0;
        feat_hist[sample_pos] = it.feature_value;
        dot_sum += (longint'(coef_q[sample_pos]) * longint'(feat_hist[sample_pos])) >>> 8;
        sample_pos++;
        if (sample_pos < span)
            return;
        used = sample_pos;
        pred32 = clamp_q16(dot_sum + longint'(bias_q));
        dot_sum = 0;
        sample_pos = 0;
        r.prediction = pred32;
        r.error = '0;
        r.updated = 1'b0;
        if (it.func == FUNC_TRAIN)
        begin
            err = longint'(pred32) - longint'($signed(it.target));
            r.error = clamp_q16(err);
            r.updated = 1'b1;
            delta = GRAD_SCALE * err;
            // weights step on the features buffered for this sample only
            for (i = 0; i < used; i++)
            begin
                g = round_shift(delta * longint'(feat_hist[i]), 8);
                step = round_shift(g * longint'(step_rate), 16);
                coef_q[i] = clamp_q16(longint'(coef_q[i]) - step);
            end
            bias_q = clamp_q16(longint'(bias_q) - round_shift(delta * longint'(step_rate), 16));
        end
        predicted_results.push_back(r);
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("%0t: %s got %h want %h", $time, field, got, want);
        mismatch_count++;
    endtask

    // mostly short gaps, a few long ones, and now and then a calm stretch
    function automatic int draw_gap(inout int calm);
        int p;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        p = $urandom_range(0, 99);
        if (p < 3)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (p < 55)
            return 0;
        if (p < 88)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int small_val(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic [15:0] rnd_feat();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3, 4, 5: return 16'(small_val(512));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rnd_q16();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h00000000;
            3, 4, 5: return 32'(small_val(1 << 18));
            default: return $urandom;
        endcase
    endfunction

    function automatic void push_feature(input logic [1:0] f, input logic [15:0] v,
                                         input logic [31:0] tgt);
        item_t it;
        it.func = f;
        it.feature_value = v;
        it.target = tgt;
        it.weight_index = 5'($urandom);
        it.weight_value = $urandom;
        item_feed.push_back(it);
    endfunction

    function automatic void push_load(input logic [4:0] idx, input logic [31:0] v);
        item_t it;
        it.func = FUNC_LOAD;
        it.feature_value = 16'($urandom);
        it.target = $urandom;
        it.weight_index = idx;
        it.weight_value = v;
        item_feed.push_back(it);
    endfunction

    // item driver
    always @(posedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else if (!item_valid || item_ready)
        begin
            if (item_gap > 0)
            begin
                item_valid <= 1'b0;
                item_gap = item_gap - 1;
            end
            else if (item_feed.size() != 0)
            begin
                item_data <= item_feed.pop_front();
                item_valid <= 1'b1;
                item_gap = draw_gap(item_calm);
            end
            else
                item_valid <= 1'b0;
        end
    end

    // result receiver stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (ready_hold > 0)
        begin
            result_ready <= 1'b0;
            ready_hold = ready_hold - 1;
        end
        else
        begin
            result_ready <= 1'b1;
            ready_hold = draw_gap(ready_calm);
        end
    end

    // monitor: register writes and item transfers feed the predictor, results are checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_LEARNING_RATE)
                    step_rate = cfg_data;
                else
                    sample_len = cfg_data[4:0];
            end
            if (item_valid && item_ready)
                regress_step(item_data);
            if (result_valid && result_ready)
            begin
                if (predicted_results.size() == 0)
                    report_mismatch("unexpected result", result_data.prediction, '0);
                else
                begin
                    next_want = predicted_results.pop_front();
                    if (result_data.prediction !== next_want.prediction)
                        report_mismatch("prediction", result_data.prediction,
                                        next_want.prediction);
                    if (result_data.error !== next_want.error)
                        report_mismatch("error", result_data.error, next_want.error);
                    if (result_data.updated !== next_want.updated)
                        report_mismatch("updated", 32'(result_data.updated),
                                        32'(next_want.updated));
                end
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [15:0] data);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // hold off until everything queued has been sent and every result has come back
    task automatic settle_block();
        do
            @(negedge clk);
        while (item_feed.size() != 0 || item_valid || predicted_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int fed;
        int phase;
        int pick;
        int eff;
        int n_samples;
        int len;
        int load_at;
        logic [4:0] cnt;
        logic [15:0] data_v;
        logic [15:0] rate_v;
        logic [1:0] mode;

        clear_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // saturation corners with three features per sample
        write_reg(REG_FEATURE_COUNT, 16'd3);
        write_reg(REG_LEARNING_RATE, 16'hffff);
        push_load(5'd0, 32'h7fffffff);
        push_load(5'd1, 32'h80000000);
        push_load(5'd2, 32'h00010000);
        push_load(BIAS_SELECT, 32'h7fffffff);
        push_load(5'd20, 32'h12345678);
        push_feature(FUNC_UNUSED, 16'h1234, 32'h0);
        push_feature(FUNC_PREDICT, 16'h7fff, 32'h0);
        push_feature(FUNC_TRAIN, 16'h8000, 32'h0);
        push_feature(FUNC_PREDICT, 16'h0100, 32'h7fffffff);
        push_feature(FUNC_PREDICT, 16'h8000, 32'h0);
        push_feature(FUNC_TRAIN, 16'h7fff, 32'h0);
        push_feature(FUNC_TRAIN, 16'h0000, 32'h80000000);
        // load lands in the middle of a sample
        push_feature(FUNC_TRAIN, 16'h0200, 32'h0);
        push_load(5'd1, 32'h00020000);
        push_feature(FUNC_TRAIN, 16'hff00, 32'h0);
        push_feature(FUNC_TRAIN, 16'h0080, 32'h7fffffff);
        settle_block();

        // zero count behaves as one, zero rate leaves weights alone
        write_reg(REG_FEATURE_COUNT, 16'd0);
        write_reg(REG_LEARNING_RATE, 16'd0);
        push_feature(FUNC_TRAIN, 16'h0100, 32'h00010000);
        push_feature(FUNC_PREDICT, 16'h8000, 32'h0);
        settle_block();

        // count above the maximum, then lowered part way through a sample
        write_reg(REG_FEATURE_COUNT, 16'hffff);
        write_reg(REG_LEARNING_RATE, 16'd655);
        repeat (5) push_feature(FUNC_TRAIN, rnd_feat(), rnd_q16());
        settle_block();
        write_reg(REG_FEATURE_COUNT, 16'd2);
        push_feature(FUNC_TRAIN, rnd_feat(), rnd_q16());
        settle_block();

        fed = 0;
        phase = 0;
        while (fed < RANDOM_ITEMS)
        begin
            if (phase == 0)
                cnt = 5'd1;
            else if (phase == 1)
                cnt = 5'd16;
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    cnt = 5'd16;
                else if (pick < 25)
                    cnt = 5'd0;
                else if (pick < 35)
                    cnt = 5'($urandom_range(17, 31));
                else if (pick < 50)
                    cnt = 5'd1;
                else
                    cnt = 5'($urandom_range(2, 6));
            end
            data_v = 16'($urandom);
            data_v[4:0] = cnt;
            if ($urandom_range(0, 1) == 0)
                data_v[15:5] = '0;
            pick = $urandom_range(0, 4);
            case (pick)
                0: rate_v = 16'd0;
                1: rate_v = 16'hffff;
                2: rate_v = LEARNING_RATE_RESET;
                3: rate_v = 16'($urandom_range(1, 2000));
                default: rate_v = 16'($urandom);
            endcase
            write_reg(REG_FEATURE_COUNT, data_v);
            write_reg(REG_LEARNING_RATE, rate_v);
            eff = (cnt == 0) ? 1 : (cnt > NFEAT) ? NFEAT : cnt;

            // pull the model back out of saturation now and then
            if ($urandom_range(0, 2) == 0)
            begin
                for (int w = 0; w <= NFEAT; w++)
                    push_load(5'(w), 32'(small_val(1 << 17)));
                fed += NFEAT + 1;
            end

            n_samples = (eff >= 12) ? 4 : 60 / eff;
            repeat (n_samples)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    if ($urandom_range(0, 1) == 0)
                        push_feature(FUNC_UNUSED, rnd_feat(), rnd_q16());
                    else
                        push_load(5'($urandom_range(17, 31)), rnd_q16());
                    fed++;
                end
                mode = ($urandom_range(0, 2) == 0) ? FUNC_PREDICT : FUNC_TRAIN;
                load_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, eff - 1) : -1;
                // a broken sample now and then leaves the next one misaligned
                len = (eff > 1 && $urandom_range(0, 19) == 0) ? $urandom_range(1, eff - 1) : eff;
                for (int k = 0; k < len; k++)
                begin
                    if (k == load_at)
                    begin
                        if ($urandom_range(0, 3) == 0)
                            push_load(5'($urandom_range(0, NFEAT)), rnd_q16());
                        else
                            push_load(5'($urandom_range(0, NFEAT)), 32'(small_val(1 << 18)));
                        fed++;
                    end
                    push_feature((k == eff - 1) ? mode : 2'($urandom_range(0, 1)),
                                 rnd_feat(), rnd_q16());
                    fed++;
                end
            end
            settle_block();
            phase++;
        end

        settle_block();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
